// ===== hdl/dbds_pkg.sv =====
// shared constants, types and verdict codes for the detection box duplicate suppressor
package dbds_pkg;

  localparam int unsigned BOX_CAPACITY = 64;
  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned IDX_W        = $clog2(BOX_CAPACITY);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned LIM_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned AREA_W       = 2 * COORD_BITS;
  localparam int unsigned CMP_W        = AREA_W + 3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
  } box_t;

  typedef enum logic [1:0] {
    VERDICT_DISTINCT  = 2'd0,
    VERDICT_DUPLICATE = 2'd1,
    VERDICT_LIMIT     = 2'd2
  } verdict_e;

endpackage

// ===== hdl/detection_box_duplicate_suppressor.sv =====
// detection box duplicate suppressor: greedy overlap test of each box against the stored list
//
// One box is taken at a time. After it is accepted the block computes the box area, then
// streams the boxes already stored for the current list out of the box store, one entry per
// cycle, through a four-stage compare pipeline (store read, edge overlap, area products,
// threshold compare). The first box of a list has nothing to compare; a box beyond the count
// limit skips the scan and is not stored. Any result may wait for the output register to
// free up. The result waits in an output register, and in_stall_o stays high from the
// accepting edge until the result has been loaded there. A duplicate is a box whose
// overlap with some earlier box of the list exceeds 0.8 of the smaller area, tested
// exactly as 5*overlap > 4*min_area; boxes whose edges only touch do not overlap.
// list_start_i clears the list before its box is handled, and after reset a new list is
// already open. The store needs no clearing.
module detection_box_duplicate_suppressor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dbds_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      list_start_i,
  input  logic [11:0]               box_left_i,
  input  logic [11:0]               box_top_i,
  input  logic [11:0]               box_width_i,
  input  logic [11:0]               box_height_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      keep_o,
  output logic [1:0]                verdict_o,
  output logic [dbds_pkg::POS_W-1:0] box_index_o
);
  import dbds_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

  function automatic coord_t span_ov(coord_t a0, coord_t al, coord_t b0, coord_t bl);
    logic [COORD_BITS:0] lo;
    logic [COORD_BITS:0] hi;
    logic [COORD_BITS:0] ea;
    logic [COORD_BITS:0] eb;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ea = {1'b0, a0} + {1'b0, al};
    eb = {1'b0, b0} + {1'b0, bl};
    hi = (ea < eb) ? ea : eb;
    if (hi > lo) begin
      span_ov = COORD_BITS'(hi - lo);
    end else begin
      span_ov = '0;
    end
  endfunction

  state_e                 state_q;
  logic [CFG_W-1:0]       max_boxes_q;
  logic [CNT_W-1:0]       count_q;
  logic [POS_W-1:0]       pos_q;
  logic [POS_W-1:0]       idx_q;
  logic [CNT_W-1:0]       iss_q;
  logic                   v0_q, v1_q, v2_q;
  logic                   hit_q;
  logic                   store_q;
  verdict_e               res_verdict_q;
  logic                   out_valid_q;
  logic                   keep_q;
  verdict_e               verdict_q;
  logic [POS_W-1:0]       index_q;

  box_t                   cand_q;
  logic [AREA_W-1:0]      cand_area_q;
  box_t                   mem_q [BOX_CAPACITY];
  box_t                   rd_q;
  coord_t                 ow_q, oh_q, sw_q, sh_q;
  logic [AREA_W-1:0]      ov_q, sarea_q;

  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic                   mem_we;
  logic [POS_W-1:0]       cur_pos;
  logic [LIM_W-1:0]       cfg_lim;
  logic [LIM_W-1:0]       limit;
  logic                   full;
  logic                   scan_end;
  logic [AREA_W-1:0]      min_area;
  logic [CMP_W-1:0]       lhs, rhs;
  logic                   cmp_hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && out_free;
  assign mem_we      = out_load && store_q;
  assign cur_pos     = list_start_i ? '0 : pos_q;

  assign cfg_lim = LIM_W'(max_boxes_q);
  assign limit   = ((max_boxes_q == '0) || (cfg_lim > LIM_W'(BOX_CAPACITY)))
                   ? LIM_W'(BOX_CAPACITY) : cfg_lim;
  assign full    = (LIM_W'(count_q) >= limit);

  assign scan_end = (iss_q == count_q) && !v0_q && !v1_q && !v2_q;

  assign min_area = (sarea_q < cand_area_q) ? sarea_q : cand_area_q;
  assign lhs      = (CMP_W'(ov_q) << 2) + CMP_W'(ov_q);
  assign rhs      = CMP_W'(min_area) << 2;
  assign cmp_hit  = (lhs > rhs);

  assign out_valid_o = out_valid_q;
  assign keep_o      = keep_q;
  assign verdict_o   = verdict_q;
  assign box_index_o = index_q;

  // box store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= cand_q;
    end
    rd_q <= mem_q[iss_q[IDX_W-1:0]];
  end

  // compare datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q.left   <= COORD_BITS'(box_left_i);
      cand_q.top    <= COORD_BITS'(box_top_i);
      cand_q.width  <= COORD_BITS'(box_width_i);
      cand_q.height <= COORD_BITS'(box_height_i);
    end
    if (state_q == ST_SETUP) begin
      cand_area_q <= AREA_W'(cand_q.width) * AREA_W'(cand_q.height);
    end
    ow_q    <= span_ov(rd_q.left, rd_q.width, cand_q.left, cand_q.width);
    oh_q    <= span_ov(rd_q.top, rd_q.height, cand_q.top, cand_q.height);
    sw_q    <= rd_q.width;
    sh_q    <= rd_q.height;
    ov_q    <= AREA_W'(ow_q) * AREA_W'(oh_q);
    sarea_q <= AREA_W'(sw_q) * AREA_W'(sh_q);
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_boxes_q   <= '0;
      count_q       <= '0;
      pos_q         <= '0;
      idx_q         <= '0;
      iss_q         <= '0;
      v0_q          <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      hit_q         <= 1'b0;
      store_q       <= 1'b0;
      res_verdict_q <= VERDICT_DISTINCT;
      out_valid_q   <= 1'b0;
      keep_q        <= 1'b0;
      verdict_q     <= VERDICT_DISTINCT;
      index_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_boxes_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= cur_pos;
            pos_q <= (cur_pos == POS_SAT) ? cur_pos : cur_pos + 1'b1;
            if (list_start_i) begin
              count_q <= '0;
            end
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          iss_q <= '0;
          hit_q <= 1'b0;
          if (full) begin
            store_q       <= 1'b0;
            res_verdict_q <= VERDICT_LIMIT;
            state_q       <= ST_DONE;
          end else begin
            store_q <= 1'b1;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (iss_q != count_q) begin
            iss_q <= iss_q + 1'b1;
            v0_q  <= 1'b1;
          end else begin
            v0_q <= 1'b0;
          end
          v1_q <= v0_q;
          v2_q <= v1_q;
          if (v2_q && cmp_hit) begin
            hit_q <= 1'b1;
          end
          if (scan_end) begin
            res_verdict_q <= hit_q ? VERDICT_DUPLICATE : VERDICT_DISTINCT;
            state_q       <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            keep_q      <= (res_verdict_q == VERDICT_DISTINCT);
            verdict_q   <= res_verdict_q;
            index_q     <= idx_q;
            if (store_q) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dbds_checker.sv =====
// port-level assertions for the detection box duplicate suppressor, with its bind
module dbds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       list_start_i,
  input logic [11:0]                box_left_i,
  input logic [11:0]                box_top_i,
  input logic [11:0]                box_width_i,
  input logic [11:0]                box_height_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       keep_o,
  input logic [1:0]                 verdict_o,
  input logic [dbds_pkg::POS_W-1:0] box_index_o
);
  import dbds_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(keep_o) && $stable(verdict_o)
      && $stable(box_index_o))
    else $error("result word changed while stalled");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(list_start_i) && $stable(box_left_i)
      && $stable(box_top_i) && $stable(box_width_i) && $stable(box_height_i))
    else $error("input word changed while stalled");

  // keep follows the verdict
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (keep_o == (verdict_o == VERDICT_DISTINCT)))
    else $error("keep disagrees with verdict");

  // only defined verdicts are delivered
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == VERDICT_DISTINCT || verdict_o == VERDICT_DUPLICATE
      || verdict_o == VERDICT_LIMIT))
    else $error("undefined verdict");

  // one box at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without working on the box");

endmodule

bind detection_box_duplicate_suppressor dbds_checker u_dbds_checker (.*);
